// ===== design/cfp_pkg.sv =====
package cfp_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned WordW    = 32;
  localparam int unsigned FrameLen = 16;
  localparam int unsigned PosW     = $clog2(FrameLen);

  // register indexes on the config port
  localparam logic RegSyncValue = 1'b0;
  localparam logic RegCommandId = 1'b1;

  localparam logic [ByteW-1:0] SyncReset = 8'hAA;
  localparam logic [ByteW-1:0] IdReset   = 8'h01;

  // width of the master tdata: mode byte plus six 32-bit words
  localparam int unsigned OutDataW = ByteW + 6 * WordW;

  // per-beat events from the parser to the counters and the output stage
  typedef struct packed {
    logic ovf;        // overflow beat taken
    logic frame_end;  // checksum byte taken
    logic bad;        // checksum mismatch, valid with frame_end
  } cfp_event_t;

  typedef struct packed {
    logic [WordW-1:0] ovf_errors;
    logic [WordW-1:0] sum_errors;
    logic [WordW-1:0] good_frames;
  } cfp_counts_t;

  typedef struct packed {
    logic [ByteW-1:0] mode;
    logic [WordW-1:0] speed;
    logic [WordW-1:0] d_cur;
    logic [WordW-1:0] q_cur;
  } cfp_fields_t;

endpackage

// ===== design/cfp_parser.sv =====
module cfp_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [cfp_pkg::ByteW-1:0]   rx_byte_i,
  input  logic                        overflow_i,
  input  logic [cfp_pkg::ByteW-1:0]   sync_value_i,
  input  logic [cfp_pkg::ByteW-1:0]   command_id_i,
  output cfp_pkg::cfp_event_t         event_o,
  output cfp_pkg::cfp_fields_t        fields_o
);
  import cfp_pkg::*;

  localparam logic [1:0] PhSync  = 2'd0;
  localparam logic [1:0] PhId    = 2'd1;
  localparam logic [1:0] PhAccum = 2'd2;

  localparam logic [PosW-1:0] PosMode   = PosW'(2);
  localparam logic [PosW-1:0] PosSpdEnd = PosW'(6);
  localparam logic [PosW-1:0] PosDEnd   = PosW'(10);
  localparam logic [PosW-1:0] PosLast   = PosW'(FrameLen - 1);

  logic [1:0]       phase_q, phase_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [ByteW-1:0] sum_q, sum_d;
  cfp_fields_t      cap_q, cap_d;
  cfp_event_t       ev;

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    sum_d   = sum_q;
    cap_d   = cap_q;
    ev      = '0;
    if (step_i) begin
      if (overflow_i) begin
        ev.ovf  = 1'b1;
        phase_d = PhSync;
        pos_d   = '0;
        sum_d   = '0;
      end else begin
        unique case (phase_q)
          PhId: begin
            // id match wins over a repeated sync
            if (rx_byte_i == command_id_i) begin
              sum_d   = sum_q + rx_byte_i;
              pos_d   = PosMode;
              phase_d = PhAccum;
            end else if (rx_byte_i == sync_value_i) begin
              sum_d = rx_byte_i;
              pos_d = PosW'(1);
            end else begin
              phase_d = PhSync;
              pos_d   = '0;
              sum_d   = '0;
            end
          end
          PhAccum: begin
            if (pos_q != PosLast) begin
              sum_d = sum_q + rx_byte_i;
              pos_d = pos_q + PosW'(1);
              priority if (pos_q == PosMode) begin
                cap_d.mode = rx_byte_i;
              end else if (pos_q <= PosSpdEnd) begin
                cap_d.speed = {cap_q.speed[WordW-ByteW-1:0], rx_byte_i};
              end else if (pos_q <= PosDEnd) begin
                cap_d.d_cur = {cap_q.d_cur[WordW-ByteW-1:0], rx_byte_i};
              end else begin
                cap_d.q_cur = {cap_q.q_cur[WordW-ByteW-1:0], rx_byte_i};
              end
            end else begin
              ev.frame_end = 1'b1;
              ev.bad       = (sum_q != rx_byte_i);
              phase_d      = PhSync;
              pos_d        = '0;
              sum_d        = '0;
            end
          end
          default: begin
            // hunting, unused code included
            if (rx_byte_i == sync_value_i) begin
              sum_d   = rx_byte_i;
              pos_d   = PosW'(1);
              phase_d = PhId;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhSync;
      pos_q   <= '0;
      sum_q   <= '0;
      cap_q   <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      sum_q   <= sum_d;
      cap_q   <= cap_d;
    end
  end

  assign event_o  = ev;
  assign fields_o = cap_q;

endmodule

// ===== design/cfp_stats.sv =====
module cfp_stats (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfp_pkg::cfp_event_t  event_i,
  output cfp_pkg::cfp_counts_t counts_next_o
);
  import cfp_pkg::*;

  cfp_counts_t cnt_q, cnt_d;

  always_comb begin
    cnt_d = cnt_q;
    if (event_i.ovf) begin
      cnt_d.ovf_errors = cnt_q.ovf_errors + WordW'(1);
    end
    if (event_i.frame_end) begin
      if (event_i.bad) begin
        cnt_d.sum_errors = cnt_q.sum_errors + WordW'(1);
      end else begin
        cnt_d.good_frames = cnt_q.good_frames + WordW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // result carries the counts after the current frame is counted
  assign counts_next_o = cnt_d;

endmodule

// ===== design/command_frame_parser_core.sv =====
// Command frame parser: takes one received serial byte per beat and reports one result
// beat per 16-byte frame (sync, command id, control byte, three big-endian 32-bit words,
// 8-bit sum checksum of bytes 0..14). A byte is taken every cycle; the result appears
// on the master side in the cycle after the checksum byte is taken and is held until
// taken. The slave side stalls only while a result waits and the master side is not
// ready. An overflow beat aborts any frame, bumps the overflow counter and produces no
// result. Unknown ids drop back to sync hunting; a sync byte inside a frame is ordinary
// data. Counters wrap at 2^32. Registers: index 0 sync byte (reset 0xAA), index 1
// command id (reset 0x01); the user must write them only while idle (not enforced).
module command_frame_parser_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config write port
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [cfp_pkg::ByteW-1:0]     cfg_data_i,
  // received bytes
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [7:0]                    s_axis_tdata_i,   // [7:0] rx_byte
  input  logic                          s_axis_tuser_i,   // [0] overflow
  // frame results
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [7:0] control_mode, [39:8] speed_bits, [71:40] d_current_bits,
  // [103:72] q_current_bits, [135:104] good_frames, [167:136] sum_errors,
  // [199:168] overflow_errors
  output logic [cfp_pkg::OutDataW-1:0]  m_axis_tdata_o,
  output logic                          m_axis_tuser_o    // [0] frame_status
);
  import cfp_pkg::*;

  logic [ByteW-1:0] sync_q, id_q;
  logic             step;
  cfp_event_t       ev;
  cfp_fields_t      fields;
  cfp_counts_t      counts_next;

  logic                out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q;
  logic                out_status_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q <= SyncReset;
      id_q   <= IdReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegSyncValue: sync_q <= cfg_data_i;
        RegCommandId: id_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // output register frees up in the same cycle it is taken
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign step            = s_axis_tvalid_i && s_axis_tready_o;

  cfp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .rx_byte_i    (s_axis_tdata_i),
    .overflow_i   (s_axis_tuser_i),
    .sync_value_i (sync_q),
    .command_id_i (id_q),
    .event_o      (ev),
    .fields_o     (fields)
  );

  cfp_stats u_stats (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .event_i       (ev),
    .counts_next_o (counts_next)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (ev.frame_end) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, loaded on the checksum beat
  always_ff @(posedge clk_i) begin
    if (ev.frame_end) begin
      out_status_q <= ev.bad;
      out_data_q   <= {counts_next.ovf_errors, counts_next.sum_errors,
                       counts_next.good_frames, fields.q_cur, fields.d_cur,
                       fields.speed, fields.mode};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_status_q;

endmodule

// ===== tb/cfp_frame_checker.sv =====
module cfp_frame_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [cfp_pkg::ByteW-1:0]     cfg_data_i,
  input  logic                          s_tvalid_i,
  input  logic                          s_tready_i,
  input  logic [7:0]                    s_tdata_i,   // [7:0] rx_byte
  input  logic                          s_tuser_i,   // [0] overflow
  input  logic                          m_tvalid_i,
  input  logic                          m_tready_i,
  // [7:0] mode, [39:8] speed, [71:40] d, [103:72] q, [135:104] good,
  // [167:136] sum errors, [199:168] overflow errors
  input  logic [cfp_pkg::OutDataW-1:0]  m_tdata_i,
  input  logic                          m_tuser_i,   // [0] frame_status
  output int unsigned                   mismatches_o,
  output int unsigned                   outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import cfp_pkg::*;

  typedef enum logic [1:0] {
    HUNT_SYNC,
    WAIT_ID,
    COLLECT
  } hunt_phase_e;

  typedef struct {
    logic        bad;
    cfp_fields_t fields;
    cfp_counts_t counts;
  } frame_report_t;

  hunt_phase_e        phase_q;
  logic [4:0]         pos_q;
  logic [ByteW-1:0]   sum_q;
  cfp_fields_t        cap_q;
  cfp_counts_t        cnt_q;
  logic [ByteW-1:0]   sync_q;
  logic [ByteW-1:0]   id_q;
  frame_report_t      expected_frames[$];
  int unsigned        mismatches;

  task automatic drop_frame();
    phase_q = HUNT_SYNC;
    pos_q   = '0;
    sum_q   = '0;
  endtask

  // advance the parser model by one received beat, queue a report on frame end
  task automatic parse_rx_beat(input logic [7:0] b, input logic ovf);
    frame_report_t rpt;
    if (ovf) begin
      cnt_q.ovf_errors = cnt_q.ovf_errors + 32'd1;
      drop_frame();
      return;
    end
    case (phase_q)
      WAIT_ID: begin
        // id match wins over a repeated sync
        if (b == id_q) begin
          sum_q   = sum_q + b;
          pos_q   = 5'd2;
          phase_q = COLLECT;
        end else if (b == sync_q) begin
          sum_q = b;
          pos_q = 5'd1;
        end else begin
          drop_frame();
        end
      end
      COLLECT: begin
        if (pos_q < FrameLen - 1) begin
          sum_q = sum_q + b;
          if (pos_q == 2)
            cap_q.mode = b;
          else if (pos_q <= 6)
            cap_q.speed = {cap_q.speed[23:0], b};
          else if (pos_q <= 10)
            cap_q.d_cur = {cap_q.d_cur[23:0], b};
          else
            cap_q.q_cur = {cap_q.q_cur[23:0], b};
          pos_q = pos_q + 5'd1;
        end else begin
          rpt.bad = (sum_q != b);
          if (rpt.bad)
            cnt_q.sum_errors = cnt_q.sum_errors + 32'd1;
          else
            cnt_q.good_frames = cnt_q.good_frames + 32'd1;
          rpt.fields = cap_q;
          rpt.counts = cnt_q;
          expected_frames.push_back(rpt);
          drop_frame();
        end
      end
      default: begin
        if (b == sync_q) begin
          sum_q   = b;
          pos_q   = 5'd1;
          phase_q = WAIT_ID;
        end
      end
    endcase
  endtask

  task automatic cmp_field(input string name, input logic [31:0] exp, input logic [31:0] act);
    if (act !== exp) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp, act);
      mismatches++;
    end
  endtask

  task automatic check_report(input frame_report_t got);
    frame_report_t exp;
    exp = expected_frames.pop_front();
    cmp_field("frame_status", 32'(exp.bad), 32'(got.bad));
    cmp_field("control_mode", 32'(exp.fields.mode), 32'(got.fields.mode));
    cmp_field("speed_bits", exp.fields.speed, got.fields.speed);
    cmp_field("d_current_bits", exp.fields.d_cur, got.fields.d_cur);
    cmp_field("q_current_bits", exp.fields.q_cur, got.fields.q_cur);
    cmp_field("good_frames", exp.counts.good_frames, got.counts.good_frames);
    cmp_field("sum_errors", exp.counts.sum_errors, got.counts.sum_errors);
    cmp_field("overflow_errors", exp.counts.ovf_errors, got.counts.ovf_errors);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    frame_report_t got;
    if (!rst_ni) begin
      drop_frame();
      cap_q      = '0;
      cnt_q      = '0;
      sync_q     = SyncReset;
      id_q       = IdReset;
      mismatches = 0;
      expected_frames.delete();
      mismatches_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got.bad                = m_tuser_i;
        got.fields.mode        = m_tdata_i[7:0];
        got.fields.speed       = m_tdata_i[39:8];
        got.fields.d_cur       = m_tdata_i[71:40];
        got.fields.q_cur       = m_tdata_i[103:72];
        got.counts.good_frames = m_tdata_i[135:104];
        got.counts.sum_errors  = m_tdata_i[167:136];
        got.counts.ovf_errors  = m_tdata_i[199:168];
        if (expected_frames.size() == 0) begin
          $display("%0t: unexpected result beat, expected none actual %0h", $time, m_tdata_i);
          mismatches++;
        end else begin
          check_report(got);
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegSyncValue: sync_q = cfg_data_i;
          RegCommandId: id_q = cfg_data_i;
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i)
        parse_rx_beat(s_tdata_i, s_tuser_i);
      mismatches_o  <= mismatches;
      outstanding_o <= expected_frames.size();
    end
  end

endmodule

// ===== tb/tb_command_frame_parser_core.sv =====
module tb_command_frame_parser_core;
  timeunit 1ns;
  timeprecision 1ps;
  import cfp_pkg::*;

  localparam int unsigned NumPhases     = 5;
  localparam int unsigned ItemsPerPhase = 330;
  localparam int unsigned HoldCycles    = 400;   // long receiver hold-off
  localparam int unsigned QuietCycles   = 4;     // result shows in the cycle after the last byte
  localparam int unsigned CycleLimit    = 300000;

  logic                 clk_i    = 1'b0;
  logic                 rst_ni   = 1'b0;
  logic                 cfg_we   = 1'b0;
  logic                 cfg_index = RegSyncValue;
  logic [ByteW-1:0]     cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata  = '0;
  logic                 s_tuser  = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OutDataW-1:0]  m_tdata;
  logic                 m_tuser;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned cycle_count = 0;
  int unsigned beats_sent  = 0;
  int unsigned burst_left  = 0;
  bit          gappy       = 1'b1;
  bit          hold_toggle = 1'b0;
  logic [7:0]  cur_sync    = SyncReset;
  logic [7:0]  cur_id      = IdReset;

  command_frame_parser_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  cfp_frame_checker u_frame_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_tvalid_i    (s_tvalid),
    .s_tready_i    (s_tready),
    .s_tdata_i     (s_tdata),
    .s_tuser_i     (s_tuser),
    .m_tvalid_i    (m_tvalid),
    .m_tready_i    (m_tready),
    .m_tdata_i     (m_tdata),
    .m_tuser_i     (m_tuser),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // watchdog on total run length
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: randomly chosen stall styles, plus one long hold-off
  // requested by the sender through hold_toggle
  initial begin
    int unsigned cyc;
    int unsigned style;
    int unsigned hold_left;
    bit          hold_seen;
    cyc       = 0;
    style     = 0;
    hold_left = 0;
    hold_seen = 1'b0;
    forever begin
      @(negedge clk_i);
      cyc++;
      if (hold_toggle != hold_seen) begin
        hold_seen = hold_toggle;
        hold_left = HoldCycles;
      end
      if (cyc % 300 == 0)
        style = $urandom_range(0, 3);
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (style)
          0: m_tready <= 1'b1;                          // no stalls
          1: m_tready <= 1'($urandom_range(0, 1));      // coin flip
          2: m_tready <= ((cyc % 7) >= 3);              // periodic stall
          default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // lower valid and keep it low for an idle stretch set by n; zero skips it
  task automatic idle_for(input int unsigned n);
    if (n == 0)
      return;
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // offer one beat and wait for the handshake, then maybe end the burst
  task automatic send_beat(input logic [7:0] b, input logic ovf);
    @(negedge clk_i);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= ovf;
    do @(posedge clk_i); while (!s_tready);
    beats_sent++;
    if (gappy) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        idle_for($urandom_range(1, 8));
      end else begin
        burst_left--;
      end
    end
  endtask

  // stop sending, wait out every result, then wait out the quiet stretch set by QuietCycles
  task automatic settle();
    idle_for(1);
    while (outstanding != 0) @(posedge clk_i);
    repeat (QuietCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // one 16-byte frame; fill picks random, all-zero, all-ones or all-sync fields;
  // abort_at below 16 swaps that byte for an overflow beat
  task automatic send_frame(input int unsigned fill, input bit corrupt,
                            input int unsigned abort_at);
    logic [7:0] body[16];
    logic [7:0] sum;
    sum     = '0;
    body[0] = cur_sync;
    body[1] = cur_id;
    for (int i = 2; i < 15; i++) begin
      case (fill)
        1: body[i] = 8'h00;
        2: body[i] = 8'hFF;
        3: body[i] = cur_sync;                          // sync byte as plain data
        default: body[i] = 8'($urandom_range(0, 255));
      endcase
    end
    for (int i = 0; i < 15; i++)
      sum = sum + body[i];
    // a nonzero xor always breaks the checksum
    body[15] = corrupt ? (sum ^ 8'($urandom_range(1, 255))) : sum;
    for (int i = 0; i < 16; i++) begin
      if (i == abort_at)
        send_beat(8'($urandom_range(0, 255)), 1'b1);
      else
        send_beat(body[i], 1'b0);
    end
  endtask

  // sync followed by an id that matches neither register
  task automatic send_bad_id();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == cur_id || b == cur_sync);
    send_beat(cur_sync, 1'b0);
    send_beat(b, 1'b0);
  endtask

  initial begin
    logic [7:0]  sync_tbl[NumPhases];
    logic [7:0]  id_tbl[NumPhases];
    int unsigned phase_start;
    int unsigned pick;
    int unsigned abort_at;
    bit          held;
    // register settings per phase: reset values, extremes, sync equal to id, random
    sync_tbl = '{8'hAA, 8'h00, 8'hFF, 8'h5A, 8'($urandom_range(0, 255))};
    id_tbl   = '{8'h01, 8'hFF, 8'h00, 8'h5A, 8'($urandom_range(0, 255))};
    held     = 1'b0;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: overflow beat, unknown id, repeated sync, all-ones frame
    gappy = 1'b0;
    send_beat(8'hFF, 1'b1);
    send_bad_id();
    send_beat(cur_sync, 1'b0);
    send_frame(2, 1'b0, 16);
    gappy = 1'b1;

    for (int p = 0; p < NumPhases; p++) begin
      if (p != 0) begin
        cur_sync = sync_tbl[p];
        cur_id   = id_tbl[p];
        write_reg(RegSyncValue, cur_sync);
        write_reg(RegCommandId, cur_id);
      end
      phase_start = beats_sent;
      while (beats_sent - phase_start < ItemsPerPhase) begin
        // long receiver hold-off while frames keep coming
        if (p == 1 && !held && beats_sent - phase_start > 100) begin
          hold_toggle <= ~hold_toggle;
          held = 1'b1;
        end
        // flip between bursty and back-to-back stretches
        if ($urandom_range(0, 19) == 0)
          gappy = !gappy;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          if ($urandom_range(0, 9) == 0)
            send_beat(cur_sync, 1'b0);                  // repeated sync lead-in
          abort_at = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 15) : 16;
          send_frame($urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 3),
                     $urandom_range(0, 3) == 0, abort_at);
        end else if (pick < 85) begin
          repeat ($urandom_range(1, 6))
            send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
        end else if (pick < 95) begin
          send_bad_id();
        end else begin
          send_beat(8'($urandom_range(0, 255)), 1'b1);
        end
      end
      // sender pauses until every result is back before the registers move
      settle();
    end

    if (mismatches == 0 && outstanding == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
